FILE: rtl/d2d_roi_pkg.sv
// Shared types and constants for the disparity-to-depth block with box test.
// Holds the beat payload structs and the configuration register indexes.
// No dependencies.
package d2d_roi_pkg;

  localparam int DISP_W  = 16;  // raw disparity, Q11.4 two's complement
  localparam int COORD_W = 12;  // pixel column and row
  localparam int DEPTH_W = 16;  // depth result
  localparam int LAT_W   = 32;  // lateral numerator and lateral limits, Q16.16
  localparam int NUM_W   = 40;  // depth numerator
  localparam int CFG_W   = 40;  // widest configuration register

  // Positive disparity magnitude (sign bit dropped).
  localparam int DMAG_W  = DISP_W - 1;
  // Quotient bits: an accepted depth is strictly below a 16-bit limit.
  localparam int QUO_W   = DEPTH_W;

  typedef enum logic [2:0] {
    CFG_LATERAL_NUM       = 3'd0,
    CFG_DEPTH_NUM         = 3'd1,
    CFG_CENTER_X          = 3'd2,
    CFG_CENTER_Y          = 3'd3,
    CFG_LIMIT_X           = 3'd4,
    CFG_LIMIT_Y           = 3'd5,
    CFG_DEPTH_LIMIT       = 3'd6,
    CFG_INVALID_DISPARITY = 3'd7
  } cfg_idx_t;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 16'hFFFF;
  localparam logic [DISP_W-1:0]  INVALID_RST     = 16'h8000;

  typedef struct packed {
    logic signed [DISP_W-1:0]  disparity;
    logic        [COORD_W-1:0] column;
    logic        [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               accepted;
  } out_t;

endpackage

FILE: rtl/disparity_to_depth_roi.sv
// Disparity to depth conversion with a box test on the back-projected point.
// Top level: configuration registers, a 17-stage pipeline and an output skid.
// Depends on d2d_roi_pkg.
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ---------------------------------
//  in_      input      in_valid / in_ready    in_t  : disparity, column, row
//  out_     output     out_valid / out_ready  out_t : depth, accepted
//  cfg_     input      cfg_valid / cfg_ready  cfg_index (cfg_idx_t), cfg_data
//
// One pixel beat is taken per cycle while the skid register is empty. The
// pipeline length is set by the restoring divider, which resolves one
// quotient bit per pipeline stage after stage 0 has captured the beat.
// Reset empties the pipeline and the output stages and loads the register
// defaults. A stall at the output fills the skid register, after which the
// whole pipeline holds; in_ready is a register and does not see out_ready.
module disparity_to_depth_roi
  import d2d_roi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,

  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_idx_t            cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // Stage 0 captures the beat; stage k (1..QUO_W) holds quotient bit QUO_W-k.
  localparam int LAST  = QUO_W;
  localparam int PX_W  = COORD_W + LAT_W;   // |column - cx| * lateral_num
  localparam int LX_W  = LAT_W + DMAG_W;    // limit_x * disparity
  localparam int DL_W  = DEPTH_W + DMAG_W;  // depth_limit * disparity
  localparam int REM_W = NUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes arrive only while the block is idle; the
  // user is bound to this, the block does not enforce it. Stages read them directly.
  // ---------------------------------------------------------------------------
  logic [LAT_W-1:0]   lateral_num_r;
  logic [NUM_W-1:0]   depth_num_r;
  logic [COORD_W-1:0] center_x_r;
  logic [COORD_W-1:0] center_y_r;
  logic [LAT_W-1:0]   limit_x_r;
  logic [LAT_W-1:0]   limit_y_r;
  logic [DEPTH_W-1:0] depth_limit_r;
  logic [DISP_W-1:0]  invalid_disp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lateral_num_r  <= '0;
      depth_num_r    <= '0;
      center_x_r     <= '0;
      center_y_r     <= '0;
      limit_x_r      <= '0;
      limit_y_r      <= '0;
      depth_limit_r  <= DEPTH_LIMIT_RST;
      invalid_disp_r <= INVALID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LATERAL_NUM:       lateral_num_r  <= cfg_data[LAT_W-1:0];
        CFG_DEPTH_NUM:         depth_num_r    <= cfg_data[NUM_W-1:0];
        CFG_CENTER_X:          center_x_r     <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y:          center_y_r     <= cfg_data[COORD_W-1:0];
        CFG_LIMIT_X:           limit_x_r      <= cfg_data[LAT_W-1:0];
        CFG_LIMIT_Y:           limit_y_r      <= cfg_data[LAT_W-1:0];
        CFG_DEPTH_LIMIT:       depth_limit_r  <= cfg_data[DEPTH_W-1:0];
        CFG_INVALID_DISPARITY: invalid_disp_r <= cfg_data[DISP_W-1:0];
        default:               lateral_num_r  <= lateral_num_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable. The whole pipeline advances together unless the skid
  // register holds a beat, so a stall neither drops nor repeats an item.
  // ---------------------------------------------------------------------------
  logic skid_valid_r;
  logic en;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage 0: capture, early rejection and absolute offsets from the centre.
  // A pixel is rejected for a zero or negative disparity, for the frame's
  // invalid marker, and for a zero depth numerator.
  // ---------------------------------------------------------------------------
  logic               v_r   [0:LAST];
  logic               bad_r [0:LAST];
  logic [DMAG_W-1:0]  d_r   [0:LAST];
  logic [REM_W-1:0]   rem_r [0:LAST];
  logic [QUO_W-1:0]   q_r   [0:LAST];

  logic               v_nxt   [0:LAST];
  logic               bad_nxt [0:LAST];
  logic [DMAG_W-1:0]  d_nxt   [0:LAST];
  logic [REM_W-1:0]   rem_nxt [0:LAST];
  logic [QUO_W-1:0]   q_nxt   [0:LAST];

  logic [COORD_W-1:0] ax_r, ay_r, ax_nxt, ay_nxt;

  always_comb begin
    ax_nxt     = (in_data.column >= center_x_r) ? in_data.column - center_x_r
                                                : center_x_r - in_data.column;
    ay_nxt     = (in_data.row >= center_y_r) ? in_data.row - center_y_r
                                             : center_y_r - in_data.row;
  end

  // ---------------------------------------------------------------------------
  // Stage 1 side products. A truncated quotient is strictly below an integer
  // limit exactly when the numerator is strictly below limit times divisor,
  // so the lateral and depth tests need multipliers only.
  // ---------------------------------------------------------------------------
  logic [PX_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic [LX_W-1:0] lx_r, ly_r, lx_nxt, ly_nxt;
  logic [DL_W-1:0] dl_r, dl_nxt;
  logic            box_fail;

  always_comb begin
    px_nxt = PX_W'(ax_r) * PX_W'(lateral_num_r);
    py_nxt = PX_W'(ay_r) * PX_W'(lateral_num_r);
    lx_nxt = LX_W'(limit_x_r) * LX_W'(d_r[0]);
    ly_nxt = LX_W'(limit_y_r) * LX_W'(d_r[0]);
    dl_nxt = DL_W'(depth_limit_r) * DL_W'(d_r[0]);
  end

  // Evaluated on stage 1 registers and folded into the flag entering stage 2.
  assign box_fail = !(LX_W'(px_r) < lx_r) || !(LX_W'(py_r) < ly_r) ||
                    !(depth_num_r < NUM_W'(dl_r));

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, most significant first.
  // For an accepted pixel the numerator is below 2^QUO_W times the divisor,
  // so QUO_W steps give the exact truncated quotient. Rejected pixels carry a
  // meaningless quotient that is masked at the output.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [REM_W:0] sub;
    logic [REM_W:0] diff;
    // Stage 0 takes the incoming beat with its early rejection flag.
    v_nxt[0]   = in_valid;
    bad_nxt[0] = (in_data.disparity == '0) || in_data.disparity[DISP_W-1] ||
                 (in_data.disparity == invalid_disp_r) || (depth_num_r == '0);
    d_nxt[0]   = in_data.disparity[DMAG_W-1:0];
    rem_nxt[0] = depth_num_r;
    q_nxt[0]   = '0;
    for (int k = 1; k <= LAST; k++) begin
      sub          = (REM_W+1)'(d_r[k-1]) << (QUO_W - k);
      diff         = {1'b0, rem_r[k-1]} - sub;
      v_nxt[k]     = v_r[k-1];
      d_nxt[k]     = d_r[k-1];
      bad_nxt[k]   = bad_r[k-1] || ((k == 2) && box_fail);
      rem_nxt[k]   = rem_r[k-1];
      q_nxt[k]     = q_r[k-1];
      if (!diff[REM_W]) begin
        rem_nxt[k]           = diff[REM_W-1:0];
        q_nxt[k][QUO_W - k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k <= LAST; k++) begin
        v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= LAST; k++) begin
        bad_r[k] <= bad_nxt[k];
        d_r[k]   <= d_nxt[k];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
      dl_r <= dl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a skid register behind it. A beat leaving the last
  // stage goes to the output register when that is free or being taken, and
  // otherwise waits in the skid register, which then holds the pipeline.
  // ---------------------------------------------------------------------------
  out_t result;
  out_t out_data_r, skid_data_r;
  logic out_valid_r;
  logic out_fire;
  logic last_fire;

  always_comb begin
    result.accepted = !bad_r[LAST];
    result.depth    = bad_r[LAST] ? '0 : q_r[LAST];
  end

  assign out_fire  = out_valid_r && out_ready;
  assign last_fire = en && v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_fire) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (last_fire) begin
        if (!out_valid_r || out_fire) begin
          out_data_r  <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= result;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/d2d_roi_checker.sv
`timescale 1ns / 1ps
// Result checker for disparity_to_depth_roi: follows the register, pixel and result
// beats, predicts each result from its own copy of the registers and compares.
// Depends on d2d_roi_pkg.
module d2d_roi_checker
  import d2d_roi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_t             out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [LAT_W-1:0]   lateral_num;
    logic [NUM_W-1:0]   depth_num;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [LAT_W-1:0]   limit_x;
    logic [LAT_W-1:0]   limit_y;
    logic [DEPTH_W-1:0] depth_limit;
    logic [DISP_W-1:0]  invalid_disparity;
  } camera_regs_t;

  typedef struct packed {
    in_t  pixel;
    out_t result;
  } depth_job_t;

  camera_regs_t cam;
  depth_job_t   expected_depths[$];

  // The lateral offsets are compared in Q16.16 at full precision, so 64 bits suffice.
  function automatic out_t predict_depth(in_t px);
    logic [DISP_W-1:0] draw;
    logic [63:0]       dx;
    logic [63:0]       dy;
    logic [63:0]       reach_x;
    logic [63:0]       reach_y;
    logic [63:0]       quo;
    logic              ok;
    out_t              res;
    draw = px.disparity;
    res  = '0;
    ok   = (draw != '0) && !draw[DISP_W-1] && (draw != cam.invalid_disparity)
           && (cam.depth_num != '0);
    if (ok) begin
      dx = (px.column >= cam.center_x) ? 64'(px.column - cam.center_x)
                                        : 64'(cam.center_x - px.column);
      dy = (px.row >= cam.center_y) ? 64'(px.row - cam.center_y)
                                     : 64'(cam.center_y - px.row);
      reach_x = (dx * 64'(cam.lateral_num)) / 64'(draw);
      reach_y = (dy * 64'(cam.lateral_num)) / 64'(draw);
      quo     = 64'(cam.depth_num) / 64'(draw);
      if (reach_x < 64'(cam.limit_x) && reach_y < 64'(cam.limit_y)
          && quo < 64'(cam.depth_limit)) begin
        res.depth    = quo[DEPTH_W-1:0];
        res.accepted = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    depth_job_t want;
    if (!rst_n) begin
      cam                   = '0;
      cam.depth_limit       = DEPTH_LIMIT_RST;
      cam.invalid_disparity = INVALID_RST;
      expected_depths.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LATERAL_NUM:       cam.lateral_num       = cfg_data[LAT_W-1:0];
          CFG_DEPTH_NUM:         cam.depth_num         = cfg_data[NUM_W-1:0];
          CFG_CENTER_X:          cam.center_x          = cfg_data[COORD_W-1:0];
          CFG_CENTER_Y:          cam.center_y          = cfg_data[COORD_W-1:0];
          CFG_LIMIT_X:           cam.limit_x           = cfg_data[LAT_W-1:0];
          CFG_LIMIT_Y:           cam.limit_y           = cfg_data[LAT_W-1:0];
          CFG_DEPTH_LIMIT:       cam.depth_limit       = cfg_data[DEPTH_W-1:0];
          CFG_INVALID_DISPARITY: cam.invalid_disparity = cfg_data[DISP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want.pixel  = in_data;
        want.result = predict_depth(in_data);
        expected_depths.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_depths.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("unexpected result beat: depth %0d accepted %0b",
                     out_data.depth, out_data.accepted);
        end else begin
          want = expected_depths.pop_front();
          if (out_data.depth !== want.result.depth
              || out_data.accepted !== want.result.accepted) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch d=%0d col=%0d row=%0d: want depth %0d acc %0b, got %0d %0b",
                       want.pixel.disparity, want.pixel.column, want.pixel.row,
                       want.result.depth, want.result.accepted,
                       out_data.depth, out_data.accepted);
          end
        end
      end
      pending <= expected_depths.size();
    end
  end

endmodule

FILE: dv/disparity_to_depth_roi_tb.sv
`timescale 1ns / 1ps
// Top of the disparity_to_depth_roi testbench: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict. Depends on d2d_roi_pkg and
// d2d_roi_checker.
module disparity_to_depth_roi_tb;
  import d2d_roi_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 135;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 800_000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors;
  int               pending;

  // Handshake between the stimulus and the receiver: a requested long hold-off,
  // and the final stretch in which neither side idles.
  bit hold_req;
  bit steady;

  // The register values last programmed, indexed by register.
  logic [CFG_W-1:0] reg_vals [8];
  in_t              directed_px [19];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  disparity_to_depth_roi DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  d2d_roi_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  // A hard stop in case the block wedges and the run never drains.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // The receiver. It mostly accepts, now and then stalls for a short burst, and
  // when asked holds out_ready low for a long, counted stretch so that the
  // pipeline and the skid fill and the block has to refuse pixel beats. Every
  // branch ends on a clock edge, so out_ready gets one assignment per step.
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic in_t pixel(logic [DISP_W-1:0] d, logic [COORD_W-1:0] c,
                                logic [COORD_W-1:0] r);
    in_t p;
    p.disparity = d;
    p.column    = c;
    p.row       = r;
    return p;
  endfunction

  // Fills the bits above a register's width with noise, which the block must
  // drop when it stores the value.
  function automatic logic [CFG_W-1:0] junk_above(logic [CFG_W-1:0] v, int w);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return CFG_W'((noise << w) | (64'(v) & ((64'd1 << w) - 64'd1)));
  endfunction

  // Offers one pixel beat and returns at the edge where it is taken. Valid is
  // left high so that a following beat can go straight out.
  task automatic send_pixel(in_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every predicted result has come back. The
  // pending count is registered in the checker, so at each edge it reflects
  // the beats up to the edge before; the first look therefore comes after the next edge.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes all eight registers back to back, then releases the channel.
  task automatic load_regs();
    for (int i = 0; i < $size(reg_vals); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= reg_vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_t              px;
    int               sel;
    int               bits;
    logic [DISP_W-1:0]  d;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LATERAL_NUM;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset values the depth numerator is zero, so every pixel is
    // rejected, whatever its disparity.
    send_pixel(pixel(16'h8000, 12'd0, 12'd0));
    send_pixel(pixel(16'd41, 12'd2048, 12'd2048));
    send_pixel(pixel(16'h7FFF, 12'd4095, 12'd0));
    send_pixel(pixel(16'd1, 12'd0, 12'd4095));
    settle();

    // Directed set-up: lateral scale 1.0, depth numerator 2^20, centre in the
    // middle of the image. At a disparity of 32 the lateral offset in Q16.16 is
    // 2048 per pixel, so a limit of 204800 puts the box edge at exactly 100
    // pixels. Depth limit 52428 is 2^20 / 20 truncated, so a disparity of 20 lands
    // on the depth edge. The invalid marker is 40, a disparity that would
    // otherwise pass.
    reg_vals[CFG_LATERAL_NUM]       = 40'h1_0000;
    reg_vals[CFG_DEPTH_NUM]         = 40'h10_0000;
    reg_vals[CFG_CENTER_X]          = 40'd2048;
    reg_vals[CFG_CENTER_Y]          = 40'd2048;
    reg_vals[CFG_LIMIT_X]           = 40'd204800;
    reg_vals[CFG_LIMIT_Y]           = 40'd204800;
    reg_vals[CFG_DEPTH_LIMIT]       = 40'd52428;
    reg_vals[CFG_INVALID_DISPARITY] = 40'd40;
    load_regs();

    directed_px = '{
      pixel(16'd0,    12'd2048, 12'd2048),   // zero disparity
      pixel(16'hFFFF, 12'd2048, 12'd2048),   // smallest negative
      pixel(16'h8000, 12'd2048, 12'd2048),   // most negative
      pixel(16'd40,   12'd2048, 12'd2048),   // the invalid marker
      pixel(16'd41,   12'd2048, 12'd2048),   // just past the marker, accepted
      pixel(16'd1,    12'd2048, 12'd2048),   // far beyond the depth limit
      pixel(16'd20,   12'd2048, 12'd2048),   // depth equal to its limit
      pixel(16'd21,   12'd2048, 12'd2048),   // depth just under its limit
      pixel(16'h7FFF, 12'd0,    12'd0),      // largest disparity, image corner
      pixel(16'h7FFF, 12'd4095, 12'd4095),   // opposite corner
      pixel(16'd32,   12'd2148, 12'd2048),   // right on the x edge
      pixel(16'd32,   12'd2147, 12'd2048),
      pixel(16'd32,   12'd1948, 12'd2048),   // left on the x edge
      pixel(16'd32,   12'd1949, 12'd2048),
      pixel(16'd32,   12'd2048, 12'd2148),   // below on the y edge
      pixel(16'd32,   12'd2048, 12'd2147),
      pixel(16'd32,   12'd2048, 12'd1948),   // above on the y edge
      pixel(16'd1,    12'd0,    12'd4095),
      pixel(16'd2047, 12'd4095, 12'd0)
    };
    foreach (directed_px[i]) send_pixel(directed_px[i]);
    settle();

    // A zero depth numerator rejects even a pixel that is otherwise ideal.
    reg_vals[CFG_DEPTH_NUM] = '0;
    load_regs();
    send_pixel(pixel(16'd41, 12'd2048, 12'd2048));
    send_pixel(pixel(16'd32, 12'd2048, 12'd2048));

    // Random phases. The first loads every register with all ones and the
    // second with all zeros; the rest draw settings in which a fair share of
    // pixels lands inside the box. The last phase runs without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: foreach (reg_vals[i]) reg_vals[i] = '1;
        1: foreach (reg_vals[i]) reg_vals[i] = '0;
        default: begin
          reg_vals[CFG_LATERAL_NUM] =
            junk_above(40'($urandom_range(0, 32'h0010_0000)), LAT_W);
          reg_vals[CFG_DEPTH_NUM] = ($urandom_range(0, 3) == 0)
            ? CFG_W'({$urandom, $urandom})
            : 40'($urandom_range(1, 32'h0400_0000));
          reg_vals[CFG_CENTER_X] = junk_above(40'($urandom_range(0, 4095)), COORD_W);
          reg_vals[CFG_CENTER_Y] = junk_above(40'($urandom_range(0, 4095)), COORD_W);
          reg_vals[CFG_LIMIT_X] = junk_above(($urandom_range(0, 1) == 0)
            ? 40'hFFFF_FFFF : 40'($urandom), LAT_W);
          reg_vals[CFG_LIMIT_Y] = junk_above(($urandom_range(0, 1) == 0)
            ? 40'hFFFF_FFFF : 40'($urandom), LAT_W);
          reg_vals[CFG_DEPTH_LIMIT] = junk_above(($urandom_range(0, 1) == 0)
            ? 40'hFFFF : 40'($urandom_range(0, 65535)), DEPTH_W);
          reg_vals[CFG_INVALID_DISPARITY] = junk_above(($urandom_range(0, 1) == 0)
            ? 40'($urandom_range(1, 4000)) : 40'($urandom), DISP_W);
        end
      endcase
      load_regs();
      steady = (ph == PHASES - 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-run, the receiver holds off for a long stretch while beats keep
        // coming, and later the sender waits for the block to empty.
        if (ph == 3 && n == 40)
          hold_req = 1'b1;
        if (ph == 5 && n == 60)
          settle();

        // Disparity: mostly positive with a random magnitude, so that both
        // near and far points appear, plus zero, the marker and negatives.
        sel = $urandom_range(0, 15);
        case (sel)
          0:       d = '0;
          1:       d = reg_vals[CFG_INVALID_DISPARITY][DISP_W-1:0];
          2, 3:    d = 16'h8000 | 16'($urandom);
          default: begin
            bits = $urandom_range(1, 15);
            d = 16'($urandom) & 16'((32'd1 << bits) - 1);
            if (d == '0)
              d = 16'd1;
          end
        endcase
        // Coordinates: often near the principal point, where the box test is
        // most likely to pass, otherwise anywhere in the image.
        if ($urandom_range(0, 2) == 0)
          c = 12'($urandom);
        else
          c = reg_vals[CFG_CENTER_X][COORD_W-1:0] + 12'($urandom_range(0, 127)) - 12'd64;
        if ($urandom_range(0, 2) == 0)
          r = 12'($urandom);
        else
          r = reg_vals[CFG_CENTER_Y][COORD_W-1:0] + 12'($urandom_range(0, 127)) - 12'd64;
        px.disparity = d;
        px.column    = c;
        px.row       = r;
        send_pixel(px);

        if (!steady && !hold_req && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end

    settle();
    // Let a stray result, if any, surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
